/* src/imhq_pkg.sv */
// Shared types and constants for the indexed min-heap queue.
package imhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 32;
  localparam int ID_COUNT = 1024;
  localparam int ID_BITS = 10;
  localparam int POS_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CHILD_BITS = POS_BITS + 2;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_BAD      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_ID_ERR   = 3'd3,
    ST_NOT_LOWER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_DECK,
    S_EXT,
    S_UPRD,
    S_UPCMP,
    S_DNRD,
    S_DNCMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [ID_BITS-1:0] element_id;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_BITS-1:0] out_id;
    logic signed [31:0] out_key;
    logic [9:0]         out_position;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [ID_BITS-1:0]         id;
  } slot_t;

endpackage

/* src/indexed_min_heap_queue.sv */
// Indexed binary min-heap priority queue with decrease-key.
//
// Requests enter on req (valid/stall): insert (id, key), extract minimum, or
// decrease the key of a present id. Each request yields exactly one response
// on rsp carrying a status, the id, the key and the final heap slot.
// Requests are handled one at a time; req_stall stays high while one is at
// work. An error, a full insert or an empty extract goes straight to the
// response; other requests may first walk the heap, a level per step. The
// next request can be taken in the cycle after the response is loaded. Each
// walk step reads the slot memory into a register, then compares and writes
// back. The response sits in an output register; a new request is taken
// while it waits, but the next response is held until rsp_stall drops.
// After reset the presence memory is cleared, one entry a cycle, all 1024
// entries; no request is accepted during that pass. Heap slot and position
// memories need no clearing: only live entries are ever read.
module indexed_min_heap_queue import imhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  slot_t              slot_mem [0:CAPACITY-1];
  logic [POS_BITS-1:0] where_mem [0:ID_COUNT-1];
  logic               present_mem [0:ID_COUNT-1];

  state_t state, state_next;
  logic [CNT_BITS-1:0] fill;
  logic [ID_BITS:0]    clr_cnt;
  logic [1:0]          cmd;
  logic [ID_BITS-1:0]  rid;
  logic signed [KEY_BITS-1:0] rkey;
  slot_t               elem;
  logic [POS_BITS-1:0] pos;
  slot_t               rd_a_q, rd_b_q;
  logic [POS_BITS-1:0] where_q;
  logic                present_q;
  rsp_t                res;

  // memory control
  logic [POS_BITS-1:0] rd_a_addr, rd_b_addr;
  logic                slot_we, where_we, pres_we;
  logic [POS_BITS-1:0] slot_waddr, where_wdata;
  slot_t               slot_wdata;
  logic [ID_BITS-1:0]  where_waddr, pres_waddr;
  logic                pres_wdata;

  logic [POS_BITS-1:0]   parent;
  logic [CHILD_BITS-1:0] child_l, child_r, fill_x;
  logic                  has_l, has_r, pick_r, up_swap, dn_swap;
  slot_t                 child;

  assign parent  = POS_BITS'((pos - 1'b1) >> 1);
  assign child_l = {1'b0, pos, 1'b1};
  assign child_r = child_l + 1'b1;
  assign fill_x  = CHILD_BITS'(fill);
  assign has_l   = child_l < fill_x;
  assign has_r   = child_r < fill_x;
  assign up_swap = $signed(elem.key) < $signed(rd_a_q.key);
  assign pick_r  = has_r && ($signed(rd_b_q.key) < $signed(rd_a_q.key));
  assign child   = pick_r ? rd_b_q : rd_a_q;
  assign dn_swap = pick_r ? ($signed(rd_b_q.key) < $signed(elem.key))
                          : ($signed(rd_a_q.key) <= $signed(elem.key));

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == (ID_BITS+1)'(ID_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:  if (req_valid) state_next = S_CHK;
      S_CHK: begin
        case (cmd)
          CMD_INSERT:   state_next = (present_q || fill == CNT_BITS'(CAPACITY)) ?
                                     S_DONE : S_UPRD;
          CMD_EXTRACT:  state_next = (fill == '0) ? S_DONE : S_EXT;
          CMD_DECREASE: state_next = present_q ? S_DECK : S_DONE;
          default:      state_next = S_DONE;
        endcase
      end
      S_DECK:  state_next = ($signed(rkey) > $signed(rd_a_q.key)) ? S_DONE : S_UPRD;
      S_EXT:   state_next = (fill == CNT_BITS'(1)) ? S_DONE : S_DNRD;
      S_UPRD:  state_next = (pos == '0) ? S_DONE : S_UPCMP;
      S_UPCMP: state_next = up_swap ? S_UPRD : S_DONE;
      S_DNRD:  state_next = has_l ? S_DNCMP : S_DONE;
      S_DNCMP: state_next = dn_swap ? S_DNRD : S_DONE;
      S_DONE:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    rd_a_addr   = parent;
    rd_b_addr   = child_r[POS_BITS-1:0];
    slot_we     = 1'b0;
    slot_waddr  = pos;
    slot_wdata  = elem;
    where_we    = 1'b0;
    where_waddr = elem.id;
    where_wdata = pos;
    pres_we     = 1'b0;
    pres_waddr  = rid;
    pres_wdata  = 1'b0;
    case (state)
      S_CLEAR: begin
        pres_we    = 1'b1;
        pres_waddr = clr_cnt[ID_BITS-1:0];
      end
      S_CHK: begin
        rd_a_addr = where_q;
        if (cmd == CMD_EXTRACT) begin
          rd_a_addr = '0;
          rd_b_addr = POS_BITS'(fill - 1'b1);
        end
        if (cmd == CMD_INSERT && !present_q && fill != CNT_BITS'(CAPACITY)) begin
          pres_we    = 1'b1;
          pres_wdata = 1'b1;
        end
      end
      S_EXT: begin
        pres_we    = 1'b1;
        pres_waddr = rd_a_q.id;
      end
      S_UPRD: begin
        if (pos == '0) begin
          slot_we  = 1'b1;
          where_we = 1'b1;
        end
      end
      S_UPCMP: begin
        slot_we  = 1'b1;
        where_we = 1'b1;
        if (up_swap) begin
          slot_wdata  = rd_a_q;
          where_waddr = rd_a_q.id;
        end
      end
      S_DNRD: begin
        rd_a_addr = child_l[POS_BITS-1:0];
        if (!has_l) begin
          slot_we  = 1'b1;
          where_we = 1'b1;
        end
      end
      S_DNCMP: begin
        slot_we  = 1'b1;
        where_we = 1'b1;
        if (dn_swap) begin
          slot_wdata  = child;
          where_waddr = child.id;
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (where_we) where_mem[where_waddr] <= where_wdata;
    if (pres_we) present_mem[pres_waddr] <= pres_wdata;
    rd_a_q    <= slot_mem[rd_a_addr];
    rd_b_q    <= slot_mem[rd_b_addr];
    where_q   <= where_mem[req.element_id];
    present_q <= present_mem[req.element_id];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd  <= req.command;
        rid  <= req.element_id;
        rkey <= req.key;
      end
      S_CHK: begin
        res.status       <= ST_OK;
        res.out_id       <= rid;
        res.out_key      <= rkey;
        res.out_position <= '0;
        elem.key <= rkey;
        elem.id  <= rid;
        case (cmd)
          CMD_INSERT: begin
            pos <= POS_BITS'(fill);
            if (present_q) res.status <= ST_ID_ERR;
            else if (fill == CNT_BITS'(CAPACITY)) res.status <= ST_FULL;
          end
          CMD_EXTRACT: begin
            pos <= '0;
            if (fill == '0) begin
              res.status  <= ST_EMPTY;
              res.out_id  <= '0;
              res.out_key <= '0;
            end
          end
          CMD_DECREASE: begin
            pos <= where_q;
            if (!present_q) res.status <= ST_ID_ERR;
          end
          default: begin
            res.status  <= ST_ID_ERR;
            res.out_id  <= '0;
            res.out_key <= '0;
          end
        endcase
      end
      S_DECK: begin
        if ($signed(rkey) > $signed(rd_a_q.key)) begin
          res.status       <= ST_NOT_LOWER;
          res.out_key      <= rd_a_q.key;
          res.out_position <= 10'(pos);
        end
      end
      S_EXT: begin
        res.out_id  <= rd_a_q.id;
        res.out_key <= rd_a_q.key;
        elem        <= rd_b_q;
      end
      S_UPRD: if (pos == '0) res.out_position <= 10'(pos);
      S_UPCMP: begin
        if (up_swap) pos <= parent;
        else res.out_position <= 10'(pos);
      end
      S_DNCMP: begin
        if (dn_swap) pos <= pick_r ? child_r[POS_BITS-1:0] : child_l[POS_BITS-1:0];
      end
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      fill      <= '0;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_CHK && cmd == CMD_INSERT && !present_q &&
          fill != CNT_BITS'(CAPACITY)) fill <= fill + 1'b1;
      if (state == S_EXT) fill <= fill - 1'b1;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
        rsp       <= res;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(CAPACITY)) else $error("fill count beyond capacity");

  a_up_nonroot: assert property (@(posedge clk) disable iff (rst)
    state == S_UPCMP |-> pos != '0) else $error("sift-up compare at root");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE)) else $error("response without finish");

  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !slot_we && !where_we) else $error("heap write during clear");

  a_dn_has_child: assert property (@(posedge clk) disable iff (rst)
    state == S_DNCMP |-> has_l) else $error("sift-down compare without child");

endmodule

/* bench/imhq_checker.sv */
// Checker for the indexed min-heap queue: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module imhq_checker import imhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  // Keys are held as signed values; signed compare gives heap order.
  logic signed [31:0] heap_key [CAPACITY];
  logic [9:0]         heap_id [CAPACITY];
  logic [9:0]         slot_of [ID_COUNT];
  logic               in_heap [ID_COUNT];
  int                 heap_size;
  rsp_t               awaited [$];

  function automatic void swap_entries(input int a, input int b);
    logic signed [31:0] k;
    logic [9:0] d;
    k = heap_key[a]; d = heap_id[a];
    heap_key[a] = heap_key[b]; heap_id[a] = heap_id[b];
    heap_key[b] = k; heap_id[b] = d;
    slot_of[heap_id[a]] = a[9:0];
    slot_of[heap_id[b]] = b[9:0];
  endfunction

  function automatic int bubble_up(input int p);
    int par;
    while (p != 0) begin
      par = (p - 1) / 2;
      if (!(heap_key[p] < heap_key[par])) break;
      swap_entries(p, par);
      p = par;
    end
    return p;
  endfunction

  function automatic void bubble_down();
    int p, l, r;
    p = 0;
    forever begin
      l = 2 * p + 1;
      r = l + 1;
      if (l >= heap_size) break;
      if (r < heap_size && heap_key[r] < heap_key[l]) begin
        if (!(heap_key[r] < heap_key[p])) break;
        swap_entries(p, r);
        p = r;
      end else begin
        if (!(heap_key[l] <= heap_key[p])) break;
        swap_entries(p, l);
        p = l;
      end
    end
  endfunction

  function automatic rsp_t predict_response(input req_t q);
    rsp_t o;
    int pos;
    o = '0;
    case (cmd_t'(q.command))
      CMD_INSERT: begin
        o.out_id = q.element_id;
        o.out_key = q.key;
        if (in_heap[q.element_id]) o.status = ST_ID_ERR;
        else if (heap_size >= CAPACITY) o.status = ST_FULL;
        else begin
          pos = heap_size;
          heap_size++;
          heap_key[pos] = q.key;
          heap_id[pos] = q.element_id;
          slot_of[q.element_id] = pos[9:0];
          in_heap[q.element_id] = 1'b1;
          o.status = ST_OK;
          o.out_position = 10'(bubble_up(pos));
        end
      end
      CMD_EXTRACT: begin
        if (heap_size == 0) o.status = ST_EMPTY;
        else begin
          o.status = ST_OK;
          o.out_id = heap_id[0];
          o.out_key = heap_key[0];
          in_heap[heap_id[0]] = 1'b0;
          if (heap_size > 1) begin
            heap_key[0] = heap_key[heap_size-1];
            heap_id[0] = heap_id[heap_size-1];
            slot_of[heap_id[0]] = '0;
          end
          heap_size--;
          bubble_down();
        end
      end
      CMD_DECREASE: begin
        o.out_id = q.element_id;
        o.out_key = q.key;
        if (!in_heap[q.element_id]) o.status = ST_ID_ERR;
        else begin
          pos = int'(slot_of[q.element_id]);
          if (q.key > heap_key[pos]) begin
            o.status = ST_NOT_LOWER;
            o.out_key = heap_key[pos];
            o.out_position = pos[9:0];
          end else begin
            heap_key[pos] = q.key;
            o.status = ST_OK;
            o.out_position = 10'(bubble_up(pos));
          end
        end
      end
      default: o.status = ST_ID_ERR;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    heap_size = 0;
    foreach (in_heap[i]) in_heap[i] = 1'b0;
  end

  always @(posedge clk) begin
    rsp_t w;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0)
          report_mismatch("unexpected response", 32'(rsp.out_id), 32'd0);
        else begin
          w = awaited.pop_front();
          if (rsp.status !== w.status)
            report_mismatch("status", 32'(rsp.status), 32'(w.status));
          if (rsp.out_id !== w.out_id)
            report_mismatch("out_id", 32'(rsp.out_id), 32'(w.out_id));
          if (rsp.out_key !== w.out_key) report_mismatch("out_key", rsp.out_key, w.out_key);
          if (rsp.out_position !== w.out_position)
            report_mismatch("out_position", 32'(rsp.out_position), 32'(w.out_position));
        end
      end
      if (req_valid && !req_stall) awaited.push_back(predict_response(req));
      pending = awaited.size();
    end
  end

endmodule

/* bench/indexed_min_heap_queue_tb.sv */
// Testbench top: drives requests into the heap queue and gives the verdict.
`timescale 1ns / 100ps
module indexed_min_heap_queue_tb import imhq_pkg::*; ();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  logic stim_done = 1'b0;
  // Ids sent in recent insert requests; some may have left the queue.
  logic [9:0] live_ids [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  indexed_min_heap_queue u_top (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp
  );

  imhq_checker u_check (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: after some responses, stall for a random number of cycles.
  always @(negedge clk) begin
    int n;
    if (rsp_valid && !rsp_stall) begin
      n = $urandom_range(0, 7);
      if (n != 0 && $urandom_range(0, 3) != 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // Hold valid across requests with no gap; drop it only for an idle gap.
  task automatic send_request(input cmd_t c, input logic [9:0] id,
                              input logic signed [31:0] k);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= '{command: c, element_id: id, key: k};
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_key();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int c;
    logic [9:0] id;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: empty extract, bad command, extreme keys and ids, errors.
    send_request(CMD_EXTRACT, 10'd0, 0);
    send_request(CMD_BAD, 10'h3ff, 32'sh7fffffff);
    send_request(CMD_DECREASE, 10'd5, 0);
    send_request(CMD_INSERT, 10'd0, 32'sh7fffffff);
    send_request(CMD_INSERT, 10'h3ff, 32'sh80000000);
    send_request(CMD_INSERT, 10'd0, 5);
    send_request(CMD_INSERT, 10'd7, 100);
    send_request(CMD_INSERT, 10'd8, 100);
    send_request(CMD_INSERT, 10'd9, 100);
    send_request(CMD_DECREASE, 10'd7, 200);
    send_request(CMD_DECREASE, 10'd8, 100);
    send_request(CMD_DECREASE, 10'd9, 32'sh80000000);
    send_request(CMD_DECREASE, 10'd0, -1);
    repeat (6) send_request(CMD_EXTRACT, 10'd0, 0);
    // Fill to capacity, then insert an id that is already present.
    for (int i = 0; i < CAPACITY; i++) live_ids.push_back(i[9:0]);
    live_ids.shuffle();
    foreach (live_ids[i]) send_request(CMD_INSERT, live_ids[i], random_key());
    send_request(CMD_INSERT, 10'd3, 0);
    // Hold until every response is back.
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 40; i++) send_request(CMD_EXTRACT, 10'd0, 0);
    live_ids.delete();
    // Random mix, mostly well-formed.
    for (int i = 0; i < 66; i++) begin
      c = $urandom_range(0, 19);
      if (c < 8) begin
        id = 10'($urandom());
        send_request(CMD_INSERT, id, random_key());
        live_ids.push_back(id);
      end else if (c < 13) begin
        send_request(CMD_EXTRACT, 10'($urandom()), $signed($urandom()));
      end else if (c < 19) begin
        if (live_ids.size() != 0 && c < 18)
          id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else id = 10'($urandom());
        send_request(CMD_DECREASE, id, random_key());
      end else begin
        send_request(CMD_BAD, 10'($urandom()), $signed($urandom()));
      end
      if (live_ids.size() > 64) live_ids.pop_front();
    end
    req_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* indexed_min_heap_queue.f */
src/imhq_pkg.sv
src/indexed_min_heap_queue.sv
bench/imhq_checker.sv
bench/indexed_min_heap_queue_tb.sv
